FILE: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Included by the modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FFHA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define FFHA_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/ffha_pkg.sv
// Types and constants for the first-fit heap allocator.
// No dependencies; used by ffha_ctrl, ffha_dp and the top level.
package ffha_pkg;

	localparam int WW = 18;
	localparam int MIN_CAP = 24;

	localparam logic [1:0] ST_ALLOC = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FREED = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_INIT,
		S_IDLE,
		S_CHK,
		S_CUR,
		S_MCHK,
		S_MRD,
		S_WB,
		S_SPLIT,
		S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLR,
		OP_INIT,
		OP_LOAD,
		OP_RD_CUR,
		OP_TAKE,
		OP_STEP,
		OP_RD_NX,
		OP_MERGE,
		OP_WB,
		OP_SPLIT,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic off_oob;
		logic rd_valid;
		logic rd_free;
		logic nx_oob;
		logic fit;
		logic split;
		logic mode;
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/ffha_in_if.sv
// Input channel of the allocator: request word with valid/ready handshake.
// No dependencies.
interface ffha_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] request_size;
	logic [11:0] free_offset;

	modport source (output valid, output mode, output request_size, output free_offset,
		input ready);
	modport sink (input valid, input mode, input request_size, input free_offset,
		output ready);
endinterface

FILE: rtl/ffha_out_if.sv
// Output channel of the allocator: result word with valid/ready handshake.
// No dependencies.
interface ffha_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] payload_offset;

	modport source (output valid, output status, output payload_offset, input ready);
	modport sink (input valid, input status, input payload_offset, output ready);
endinterface

FILE: rtl/ffha_ctrl.sv
// Controller state machine of the allocator: walk, merge, write back, split.
// Depends on ffha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  ffha_pkg::sts_t  sts,
	output ffha_pkg::cmd_t  cmd
);

	ffha_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ffha_pkg::S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::S_CLEAR: if (sts.clr_last) state_d = ffha_pkg::S_INIT;
			ffha_pkg::S_INIT:  state_d = ffha_pkg::S_IDLE;
			ffha_pkg::S_IDLE:  if (in_valid) state_d = ffha_pkg::S_CHK;
			ffha_pkg::S_CHK:   state_d = sts.off_oob ? ffha_pkg::S_FIN : ffha_pkg::S_CUR;
			ffha_pkg::S_CUR: begin
				if (!sts.rd_valid) state_d = ffha_pkg::S_FIN;
				else if (sts.mode || sts.rd_free) state_d = ffha_pkg::S_MCHK;
				else state_d = ffha_pkg::S_CHK;
			end
			ffha_pkg::S_MCHK:  state_d = sts.nx_oob ? ffha_pkg::S_WB : ffha_pkg::S_MRD;
			ffha_pkg::S_MRD:
				state_d = (sts.rd_valid && sts.rd_free) ? ffha_pkg::S_MCHK : ffha_pkg::S_WB;
			ffha_pkg::S_WB: begin
				if (sts.mode) state_d = ffha_pkg::S_FIN;
				else if (!sts.fit) state_d = ffha_pkg::S_CHK;
				else if (sts.split) state_d = ffha_pkg::S_SPLIT;
				else state_d = ffha_pkg::S_FIN;
			end
			ffha_pkg::S_SPLIT: state_d = ffha_pkg::S_FIN;
			ffha_pkg::S_FIN:   if (!sts.out_busy) state_d = ffha_pkg::S_IDLE;
			default:           state_d = ffha_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd.op = ffha_pkg::OP_NOP;
		cmd.in_ready = 1'b0;
		case (state_q)
			ffha_pkg::S_CLEAR: cmd.op = ffha_pkg::OP_CLR;
			ffha_pkg::S_INIT:  cmd.op = ffha_pkg::OP_INIT;
			ffha_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) cmd.op = ffha_pkg::OP_LOAD;
			end
			ffha_pkg::S_CHK:   if (!sts.off_oob) cmd.op = ffha_pkg::OP_RD_CUR;
			ffha_pkg::S_CUR: begin
				if (sts.rd_valid) begin
					if (sts.mode || sts.rd_free) cmd.op = ffha_pkg::OP_TAKE;
					else cmd.op = ffha_pkg::OP_STEP;
				end
			end
			ffha_pkg::S_MCHK:  cmd.op = ffha_pkg::OP_RD_NX;
			ffha_pkg::S_MRD:   if (sts.rd_valid && sts.rd_free) cmd.op = ffha_pkg::OP_MERGE;
			ffha_pkg::S_WB:    cmd.op = ffha_pkg::OP_WB;
			ffha_pkg::S_SPLIT: cmd.op = ffha_pkg::OP_SPLIT;
			ffha_pkg::S_FIN:   if (!sts.out_busy) cmd.op = ffha_pkg::OP_FIN;
			default:           cmd.op = ffha_pkg::OP_NOP;
		endcase
	end

	`FFHA_ASSERT(a_clear_exit, state_q == ffha_pkg::S_CLEAR && sts.clr_last |=> state_q == ffha_pkg::S_INIT, "clear sweep did not end in init")
	`FFHA_ASSERT(a_fin_idle, state_q == ffha_pkg::S_FIN && !sts.out_busy |=> state_q == ffha_pkg::S_IDLE, "finished word not released")
	`FFHA_NEVER(a_split_free, state_q == ffha_pkg::S_SPLIT && sts.mode, "split during free")

endmodule

FILE: rtl/ffha_dp.sv
// Datapath of the allocator: header memory, walk offset, capacity and result registers.
// Depends on ffha_pkg, ffha_in_if, ffha_out_if and assert_macros.svh.
`include "assert_macros.svh"

module ffha_dp #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 17
) (
	input  logic            clk,
	input  logic            arst_n,
	ffha_in_if.sink         in_ch,
	ffha_out_if.source      out_ch,
	input  ffha_pkg::cmd_t  cmd,
	output ffha_pkg::sts_t  sts
);

	localparam int AW  = $clog2(HEAP_BYTES);
	localparam int ENW = AW + 2;
	localparam int WW  = ffha_pkg::WW;
	localparam logic [WW-1:0] HB = WW'(HEAP_BYTES);
	localparam logic [WW-1:0] HH = WW'(HEADER_BYTES);
	localparam logic [WW-1:0] MC = WW'(ffha_pkg::MIN_CAP);
	localparam logic [AW-1:0] CAP0 = AW'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [AW-1:0] LAST = AW'(HEAP_BYTES - 1);

	logic [ENW-1:0] mem [HEAP_BYTES];
	logic [ENW-1:0] rd_q;
	logic [WW-1:0]  off_q;
	logic [AW-1:0]  cap_q;
	logic [15:0]    q_q;
	logic           mode_q;
	logic           ok_q;
	logic [AW-1:0]  clr_q;
	logic           ovalid_q;
	logic [1:0]     status_q;
	logic [11:0]    payload_q;

	logic           rd_valid, rd_free;
	logic [AW-1:0]  rd_cap;
	logic [WW-1:0]  cap_w, q_w, nx_w, step_w, spl_w, pay_w, req_w;
	logic           fit, split;
	logic           we, re;
	logic [AW-1:0]  waddr, raddr;
	logic [ENW-1:0] wdata;

	assign rd_valid = rd_q[ENW-1];
	assign rd_free  = rd_q[ENW-2];
	assign rd_cap   = rd_q[AW-1:0];
	assign cap_w    = WW'(cap_q);
	assign q_w      = WW'(q_q);
	assign nx_w     = off_q + HH + cap_w;
	assign step_w   = off_q + HH + WW'(rd_cap);
	assign spl_w    = off_q + HH + q_w;
	assign pay_w    = off_q + HH;
	assign req_w    = WW'(in_ch.request_size);
	assign fit      = cap_w >= q_w;
	assign split    = (q_w + HH + MC) <= cap_w;

	always_comb begin
		we = 1'b0;
		waddr = off_q[AW-1:0];
		wdata = '0;
		case (cmd.op)
			ffha_pkg::OP_CLR: begin
				we = 1'b1;
				waddr = clr_q;
			end
			ffha_pkg::OP_INIT: begin
				we = 1'b1;
				waddr = '0;
				wdata = {2'b11, CAP0};
			end
			ffha_pkg::OP_MERGE: begin
				we = 1'b1;
				waddr = nx_w[AW-1:0];
			end
			ffha_pkg::OP_WB: begin
				we = 1'b1;
				if (!mode_q && fit) wdata = {2'b10, split ? q_q[AW-1:0] : cap_q};
				else wdata = {2'b11, cap_q};
			end
			ffha_pkg::OP_SPLIT: begin
				we = 1'b1;
				waddr = spl_w[AW-1:0];
				wdata = {2'b11, AW'(cap_w - q_w - HH)};
			end
			default: we = 1'b0;
		endcase
	end

	assign re    = (cmd.op == ffha_pkg::OP_RD_CUR) || (cmd.op == ffha_pkg::OP_RD_NX);
	assign raddr = (cmd.op == ffha_pkg::OP_RD_NX) ? nx_w[AW-1:0] : off_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == ffha_pkg::OP_CLR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ffha_pkg::OP_LOAD: begin
				mode_q <= in_ch.mode;
				ok_q <= 1'b0;
				q_q <= (req_w < MC) ? 16'(ffha_pkg::MIN_CAP) : in_ch.request_size;
				off_q <= in_ch.mode ? (WW'(in_ch.free_offset) - HH) : '0;
			end
			ffha_pkg::OP_TAKE:  cap_q <= rd_cap;
			ffha_pkg::OP_STEP:  off_q <= step_w;
			ffha_pkg::OP_MERGE: cap_q <= AW'(cap_w + HH + WW'(rd_cap));
			ffha_pkg::OP_WB: begin
				if (!mode_q && fit) ok_q <= 1'b1;
				if (!mode_q && !fit) off_q <= nx_w;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.op == ffha_pkg::OP_FIN) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ffha_pkg::OP_FIN) begin
			status_q <= mode_q ? ffha_pkg::ST_FREED :
				(ok_q ? ffha_pkg::ST_ALLOC : ffha_pkg::ST_NOFIT);
			payload_q <= (!mode_q && ok_q) ? pay_w[11:0] : 12'd0;
		end
	end

	assign out_ch.valid          = ovalid_q;
	assign out_ch.status         = status_q;
	assign out_ch.payload_offset = payload_q;

	assign sts.clr_last = clr_q == LAST;
	assign sts.off_oob  = off_q >= HB;
	assign sts.rd_valid = rd_valid;
	assign sts.rd_free  = rd_free;
	assign sts.nx_oob   = nx_w >= HB;
	assign sts.fit      = fit;
	assign sts.split    = split;
	assign sts.mode     = mode_q;
	assign sts.out_busy = ovalid_q && !out_ch.ready;

	`FFHA_ASSERT(a_merge_src, cmd.op == ffha_pkg::OP_MERGE |-> rd_valid && rd_free && !sts.nx_oob, "merge of a non-free neighbor")
	`FFHA_ASSERT(a_split_fit, cmd.op == ffha_pkg::OP_SPLIT |-> spl_w < HB, "split header beyond heap")
	`FFHA_NEVER(a_fin_busy, cmd.op == ffha_pkg::OP_FIN && sts.out_busy, "result overwrote a pending word")

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator top level: controller plus datapath.
// Depends on ffha_pkg, ffha_in_if, ffha_out_if, ffha_ctrl and ffha_dp.
//
// in_ch carries one request word: mode 0 allocates request_size bytes (raised
// to at least 24), mode 1 frees the block whose payload sits at free_offset.
// out_ch returns one word per request: status 0 allocated with payload_offset,
// 1 no block fits, 2 freed.
// Requests are handled one at a time. An allocate walks the headers from
// offset 0: it steps past used blocks, merges free neighbors into a free
// block, then takes the block if it fits, splitting off the rest when large
// enough, or moves on, and reports no fit at the heap end. A free merges the
// following free neighbors and marks it free; the next word is taken in idle.
// The walk is set by the header memory, one header read or write per cycle.
// After reset the header memory is swept clear, one entry per cycle, and the
// first free header is written; in_ch.ready stays low until it ends.
// The result sits in an output register; a new request is taken while it
// waits, and a finished result holds the block until out_ch.ready frees it.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	ffha_in_if.sink     in_ch,
	ffha_out_if.source  out_ch
);

	ffha_pkg::cmd_t cmd;
	ffha_pkg::sts_t sts;

	assign in_ch.ready = cmd.in_ready;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffha_dp #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
